// ===== hw/rtl/scfr_pkg.sv =====
// Shared types and constants for the serial command frame responder.
`default_nettype none

package scfr_pkg;

  localparam logic [7:0] START_BYTE   = 8'h41;
  localparam logic [7:0] PAD_BYTE     = 8'hff;
  localparam logic [7:0] BCAST_ID     = 8'd255;
  localparam logic [7:0] CMD_ECHO     = 8'd0;
  localparam logic [7:0] CMD_SET_ID   = 8'd254;
  localparam logic [7:0] CMD_GET_ID   = 8'd253;
  localparam logic [7:0] CMD_ID_REPLY = 8'd250;
  localparam logic [7:0] RESET_ID     = 8'd10;

  localparam int JOB_DEPTH = 2;

  typedef enum logic [1:0] {
    EV_REPLY = 2'd0,
    EV_USER  = 2'd1,
    EV_STORE = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ID,
    PH_CMD,
    PH_DL,
    PH_DH,
    PH_SUM
  } phase_t;

  // Work handed from the frame parser to the result sequencer.
  typedef struct packed {
    logic       store;
    logic       reply;
    logic       user;
    logic [7:0] id;
    logic [7:0] cmd;
    logic [7:0] dl;
    logic [7:0] dh;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scfr_front.sv =====
// Frame parser: hunts for the start byte, checks the frame and classifies it into a job.
`default_nettype none

module scfr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [7:0]    rx_byte,
  output logic               full,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          q_full,
  output logic               q_push,
  output scfr_pkg::job_t     q_job
);

  scfr_pkg::phase_t phase, phase_next;
  logic [7:0] running_sum;
  logic [7:0] node_id, node_id_next;
  logic [7:0] f_id, f_cmd, f_dl, f_dh;
  logic       accept;
  logic       sum_ok, bcast, mine;

  // Only the checksum byte can produce a job, so only it waits on the queue.
  assign full   = (phase == scfr_pkg::PH_SUM) && q_full;
  assign accept = push && !full;

  assign sum_ok = (running_sum == rx_byte);
  assign bcast  = (f_id == scfr_pkg::BCAST_ID);
  assign mine   = (f_id == node_id);

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        scfr_pkg::PH_HUNT: begin
          if (rx_byte == scfr_pkg::START_BYTE) phase_next = scfr_pkg::PH_ID;
        end
        scfr_pkg::PH_ID:  phase_next = scfr_pkg::PH_CMD;
        scfr_pkg::PH_CMD: phase_next = scfr_pkg::PH_DL;
        scfr_pkg::PH_DL:  phase_next = scfr_pkg::PH_DH;
        scfr_pkg::PH_DH:  phase_next = scfr_pkg::PH_SUM;
        scfr_pkg::PH_SUM: phase_next = scfr_pkg::PH_HUNT;
        default:          phase_next = scfr_pkg::PH_HUNT;
      endcase
    end
  end

  always_comb begin
    q_push       = 1'b0;
    q_job        = '0;
    q_job.id     = node_id;
    q_job.cmd    = f_cmd;
    q_job.dl     = f_dl;
    q_job.dh     = f_dh;
    node_id_next = node_id;
    if (accept && (phase == scfr_pkg::PH_SUM) && sum_ok && (bcast || mine)) begin
      unique case (f_cmd)
        scfr_pkg::CMD_ECHO: begin
          q_job.reply = !bcast;
          q_push      = !bcast;
        end
        scfr_pkg::CMD_SET_ID: begin
          // The reply to a set-id frame already carries the new id.
          node_id_next = f_dl;
          q_job.id     = f_dl;
          q_job.store  = 1'b1;
          q_job.reply  = !bcast;
          q_push       = 1'b1;
        end
        scfr_pkg::CMD_GET_ID: begin
          q_job.cmd   = scfr_pkg::CMD_ID_REPLY;
          q_job.dl    = node_id;
          q_job.dh    = 8'd0;
          q_job.reply = 1'b1;
          q_push      = 1'b1;
        end
        default: begin
          q_job.user = 1'b1;
          q_push     = 1'b1;
        end
      endcase
    end
    if (cfg_we) node_id_next = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= scfr_pkg::PH_HUNT;
      running_sum <= 8'd0;
      node_id     <= scfr_pkg::RESET_ID;
    end else begin
      phase   <= phase_next;
      node_id <= node_id_next;
      if (accept) begin
        if (phase == scfr_pkg::PH_HUNT) begin
          running_sum <= 8'd0;
        end else if (phase != scfr_pkg::PH_SUM) begin
          running_sum <= running_sum + rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (phase)
        scfr_pkg::PH_ID:  f_id  <= rx_byte;
        scfr_pkg::PH_CMD: f_cmd <= rx_byte;
        scfr_pkg::PH_DL:  f_dl  <= rx_byte;
        scfr_pkg::PH_DH:  f_dh  <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scfr_job_fifo.sv =====
// Small job queue between the frame parser and the result sequencer.
`default_nettype none

module scfr_job_fifo #(
  parameter int Depth = scfr_pkg::JOB_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire scfr_pkg::job_t wr_job,
  output logic                full,
  input  wire logic           rd,
  output scfr_pkg::job_t      rd_job,
  output logic                empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  scfr_pkg::job_t  mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr, do_rd;

  assign full   = (count == FullCnt);
  assign empty  = (count == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_job;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scfr_back.sv =====
// Result sequencer: expands each job into its store, reply and user-command results.
`default_nettype none

module scfr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire scfr_pkg::job_t q_job,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output logic [1:0]          event_res,
  output logic [7:0]          tx_byte,
  output logic                last,
  output logic [7:0]          user_cmd,
  output logic signed [15:0]  user_data,
  output logic [7:0]          stored_id
);

  scfr_pkg::job_t job;
  logic           busy;
  logic [3:0]     step;
  logic [3:0]     count;
  logic [2:0]     ridx;
  logic [7:0]     sum;
  logic           adv, load;

  assign empty = !busy;
  assign count = {3'd0, job.store} + {job.reply, 3'd0} + {3'd0, job.user};
  assign last  = busy && (step == count - 4'd1);
  assign adv   = pop && busy;
  assign load  = (!busy || (adv && last)) && !q_empty;
  assign q_pop = load;
  assign ridx  = 3'(step - {3'd0, job.store});
  assign sum   = job.id + job.cmd + job.dl + job.dh;

  always_comb begin
    event_res = scfr_pkg::EV_REPLY;
    tx_byte   = 8'd0;
    user_cmd  = 8'd0;
    user_data = '0;
    stored_id = 8'd0;
    if (job.user) begin
      event_res = scfr_pkg::EV_USER;
      user_cmd  = job.cmd;
      user_data = {job.dh, job.dl};
    end else if (job.store && (step == 4'd0)) begin
      event_res = scfr_pkg::EV_STORE;
      stored_id = job.dl;
    end else begin
      case (ridx)
        3'd0:    tx_byte = scfr_pkg::PAD_BYTE;
        3'd1:    tx_byte = scfr_pkg::START_BYTE;
        3'd2:    tx_byte = job.id;
        3'd3:    tx_byte = job.cmd;
        3'd4:    tx_byte = job.dl;
        3'd5:    tx_byte = job.dh;
        3'd6:    tx_byte = sum;
        default: tx_byte = scfr_pkg::PAD_BYTE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 4'd0;
    end else if (load) begin
      busy <= 1'b1;
      step <= 4'd0;
      job  <= q_job;
    end else if (adv && last) begin
      busy <= 1'b0;
    end else if (adv) begin
      step <= step + 4'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/serial_command_frame_responder.sv =====
// Top level of the serial command frame responder.
`default_nettype none

// Takes one received byte per transfer, at up to one per cycle, and delivers
// results one per cycle while pop is held. A parser hunts for 0x41, collects
// id, command, data and checksum, and hands each frame that needs an answer
// to a short job queue (QDepth entries); a sequencer turns each job into its
// results: an optional store-id request, an 8-byte reply, or a user-command
// event. Input stalls (full) only on a checksum byte while the job queue is
// full, so the sustained input rate is set by the sequencer's one result per
// cycle at best: a 6-byte frame can draw an 8-byte reply. A configuration
// write of default_id reloads the node id at once.
module serial_command_frame_responder #(
  parameter int QDepth = scfr_pkg::JOB_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_data,
  output logic               empty,
  input  wire logic          pop,
  output logic [1:0]         event_res,
  output logic [7:0]         tx_byte,
  output logic               last,
  output logic [7:0]         user_cmd,
  output logic signed [15:0] user_data,
  output logic [7:0]         stored_id
);

  scfr_pkg::job_t in_job, out_job;
  logic           q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  scfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rx_byte  (rx_byte),
    .full     (full),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (in_job)
  );

  scfr_job_fifo #(
    .Depth (QDepth)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_job (in_job),
    .full   (q_full),
    .rd     (q_pop),
    .rd_job (out_job),
    .empty  (q_empty)
  );

  scfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (out_job),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .event_res (event_res),
    .tx_byte   (tx_byte),
    .last      (last),
    .user_cmd  (user_cmd),
    .user_data (user_data),
    .stored_id (stored_id)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the serial command frame responder.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 36;
  localparam int LONG_HOLD     = 400;

  typedef struct packed {
    scfr_pkg::event_t ev;
    logic [7:0]       tx;
    logic             last;
    logic [7:0]       cmd;
    logic [15:0]      data;
    logic [7:0]       sid;
  } result_t;

  // One row of the directed table: a byte, and optionally a typed-in outcome.
  typedef struct {
    logic [7:0] rx;
    bit         typed;
    bit         has_res;
    result_t    res;
  } row_t;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic [7:0]        rx_byte;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_data;
  logic              empty;
  logic              pop;
  logic [1:0]        event_res;
  logic [7:0]        tx_byte;
  logic              last;
  logic [7:0]        user_cmd;
  logic signed [15:0] user_data;
  logic [7:0]        stored_id;

  serial_command_frame_responder u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .event_res (event_res),
    .tx_byte   (tx_byte),
    .last      (last),
    .user_cmd  (user_cmd),
    .user_data (user_data),
    .stored_id (stored_id)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow state of the responder.
  scfr_pkg::phase_t parse_phase;
  logic [7:0] frame_fields [4];
  logic [7:0] field_sum;
  logic [7:0] node_id;

  result_t pending_results[$];
  result_t step_results[$];
  row_t    frame_table[$];

  int mismatch_count = 0;
  int hold_request   = 0;
  int burst_left     = 0;
  bit steady_sender  = 1'b0;
  int frame_items    = 0;

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatch_count++;
    $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  function automatic void emit_result(scfr_pkg::event_t ev, logic [7:0] tx, logic [7:0] cmd,
                                      logic [15:0] data, logic [7:0] sid);
    result_t r;
    r.ev = ev;
    r.tx = tx;
    r.last = 1'b0;
    r.cmd = cmd;
    r.data = data;
    r.sid = sid;
    step_results.push_back(r);
  endfunction

  function automatic void emit_reply(logic [7:0] cmd, logic [7:0] dl, logic [7:0] dh);
    logic [7:0] sum;
    sum = node_id + cmd + dl + dh;
    emit_result(scfr_pkg::EV_REPLY, scfr_pkg::PAD_BYTE, '0, '0, '0);
    emit_result(scfr_pkg::EV_REPLY, scfr_pkg::START_BYTE, '0, '0, '0);
    emit_result(scfr_pkg::EV_REPLY, node_id, '0, '0, '0);
    emit_result(scfr_pkg::EV_REPLY, cmd, '0, '0, '0);
    emit_result(scfr_pkg::EV_REPLY, dl, '0, '0, '0);
    emit_result(scfr_pkg::EV_REPLY, dh, '0, '0, '0);
    emit_result(scfr_pkg::EV_REPLY, sum, '0, '0, '0);
    emit_result(scfr_pkg::EV_REPLY, scfr_pkg::PAD_BYTE, '0, '0, '0);
  endfunction

  // Advances the shadow parser by one received byte; the results it causes
  // are left in step_results.
  function automatic void parse_byte(logic [7:0] b);
    logic [7:0] id;
    logic [7:0] cmd;
    logic [7:0] dl;
    logic [7:0] dh;
    bit         bcast;
    step_results.delete();
    case (parse_phase)
      scfr_pkg::PH_HUNT: begin
        if (b == scfr_pkg::START_BYTE) begin
          parse_phase = scfr_pkg::PH_ID;
          field_sum = '0;
        end
      end
      scfr_pkg::PH_SUM: begin
        parse_phase = scfr_pkg::PH_HUNT;
        id = frame_fields[0];
        cmd = frame_fields[1];
        dl = frame_fields[2];
        dh = frame_fields[3];
        bcast = (id == scfr_pkg::BCAST_ID);
        if (field_sum == b && (bcast || id == node_id)) begin
          if (cmd == scfr_pkg::CMD_ECHO) begin
            if (!bcast) emit_reply(cmd, dl, dh);
          end else if (cmd == scfr_pkg::CMD_SET_ID) begin
            node_id = dl;
            emit_result(scfr_pkg::EV_STORE, '0, '0, '0, dl);
            if (!bcast) emit_reply(cmd, dl, dh);
          end else if (cmd == scfr_pkg::CMD_GET_ID) begin
            emit_reply(scfr_pkg::CMD_ID_REPLY, node_id, 8'h00);
          end else begin
            emit_result(scfr_pkg::EV_USER, '0, cmd, {dh, dl}, '0);
          end
        end
      end
      default: begin
        frame_fields[2'(int'(parse_phase) - 1)] = b;
        field_sum = field_sum + b;
        parse_phase = scfr_pkg::phase_t'(parse_phase + 1);
      end
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  task automatic pause_sender(input int n);
    @(negedge clk);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Offers one byte, waits for its transfer, and queues what it should cause.
  task automatic transfer_byte(input logic [7:0] b, input bit typed, input bit has_res,
                               input result_t res);
    @(negedge clk);
    push <= 1'b1;
    rx_byte <= b;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    parse_byte(b);
    if (typed) begin
      if (has_res) pending_results.push_back(res);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
    if (!steady_sender) begin
      if (burst_left <= 0) begin
        pause_sender($urandom_range(1, 6));
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_plain(input logic [7:0] b);
    transfer_byte(b, 1'b0, 1'b0, '0);
  endtask

  task automatic wait_drained();
    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_default_id(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    node_id = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(logic [7:0] rx, bit typed, bit has_res, result_t res);
    row_t row;
    row.rx = rx;
    row.typed = typed;
    row.has_res = has_res;
    row.res = res;
    frame_table.push_back(row);
  endfunction

  function automatic result_t user_event(logic [7:0] cmd, logic [15:0] data);
    return '{ev: scfr_pkg::EV_USER, tx: 8'h00, last: 1'b1, cmd: cmd, data: data,
             sid: 8'h00};
  endfunction

  function automatic result_t store_event(logic [7:0] sid);
    return '{ev: scfr_pkg::EV_STORE, tx: 8'h00, last: 1'b1, cmd: 8'h00, data: 16'h0000,
             sid: sid};
  endfunction

  // A frame with random content, mostly well formed; some are preceded by
  // noise, carry a bad checksum, or are cut short.
  task automatic send_random_frame();
    logic [7:0] id;
    logic [7:0] cmd;
    logic [7:0] dl;
    logic [7:0] dh;
    logic [7:0] chk;
    logic [7:0] noise;
    logic [7:0] bytes [6];
    int         pick;
    int         cut;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        noise = 8'($urandom_range(0, 255));
        if (noise == scfr_pkg::START_BYTE) noise = ~noise;
        send_plain(noise);
      end
    end
    pick = $urandom_range(0, 9);
    if (pick <= 5) id = node_id;
    else if (pick <= 7) id = scfr_pkg::BCAST_ID;
    else id = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick <= 3) cmd = scfr_pkg::CMD_ECHO;
    else if (pick == 4) cmd = scfr_pkg::CMD_SET_ID;
    else if (pick <= 6) cmd = scfr_pkg::CMD_GET_ID;
    else cmd = 8'($urandom_range(0, 255));
    dl = 8'($urandom_range(0, 255));
    dh = 8'($urandom_range(0, 255));
    chk = id + cmd + dl + dh;
    if ($urandom_range(0, 9) == 0) chk = chk + 8'($urandom_range(1, 255));
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 5) : 6;
    bytes = '{scfr_pkg::START_BYTE, id, cmd, dl, dh, chk};
    for (int i = 0; i < cut; i++) send_plain(bytes[i]);
    frame_items += cut;
  endtask

  // Result side: stalls on its own pattern and checks every transfer.
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    bit take;
    result_t want;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left <= 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (mode)
        0: take = 1'b1;
        1: take = 1'($urandom_range(0, 1));
        2: take = (mode_left % 4) != 0;
        default: take = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end
      pop <= take;
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result with nothing expected", tx_byte, 0);
        end else begin
          want = pending_results.pop_front();
          if (event_res != want.ev) note_mismatch("event_res", event_res, want.ev);
          if (tx_byte != want.tx) note_mismatch("tx_byte", tx_byte, want.tx);
          if (last != want.last) note_mismatch("last", last, want.last);
          if (user_cmd != want.cmd) note_mismatch("user_cmd", user_cmd, want.cmd);
          if ($unsigned(user_data) != want.data)
            note_mismatch("user_data", $unsigned(user_data), want.data);
          if (stored_id != want.sid) note_mismatch("stored_id", stored_id, want.sid);
        end
      end
    end
  end

  initial begin
    logic [7:0] phase_ids [5];
    push = 1'b0;
    rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rst = 1'b1;
    parse_phase = scfr_pkg::PH_HUNT;
    field_sum = '0;
    node_id = scfr_pkg::RESET_ID;
    foreach (frame_fields[i]) frame_fields[i] = '0;

    // Echo to the reset id, with all-zero data.
    add_row(scfr_pkg::START_BYTE, 1'b0, 1'b0, '0);
    add_row(8'h0a, 1'b0, 1'b0, '0);
    add_row(scfr_pkg::CMD_ECHO, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h0a, 1'b0, 1'b0, '0);
    // Broadcast user command whose command byte is the start byte.
    add_row(scfr_pkg::START_BYTE, 1'b0, 1'b0, '0);
    add_row(scfr_pkg::BCAST_ID, 1'b0, 1'b0, '0);
    add_row(scfr_pkg::START_BYTE, 1'b0, 1'b0, '0);
    add_row(8'hff, 1'b0, 1'b0, '0);
    add_row(8'hff, 1'b0, 1'b0, '0);
    add_row(8'h3e, 1'b1, 1'b1, user_event(scfr_pkg::START_BYTE, 16'hffff));
    // Set id by broadcast: store request, no reply.
    add_row(scfr_pkg::START_BYTE, 1'b0, 1'b0, '0);
    add_row(scfr_pkg::BCAST_ID, 1'b0, 1'b0, '0);
    add_row(scfr_pkg::CMD_SET_ID, 1'b0, 1'b0, '0);
    add_row(8'h7f, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'hfc, 1'b1, 1'b1, store_event(8'h7f));
    // Bad checksum to the new id: dropped.
    add_row(scfr_pkg::START_BYTE, 1'b0, 1'b0, '0);
    add_row(8'h7f, 1'b0, 1'b0, '0);
    add_row(scfr_pkg::CMD_ECHO, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h02, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, '0);
    // Get id from the new id.
    add_row(scfr_pkg::START_BYTE, 1'b0, 1'b0, '0);
    add_row(8'h7f, 1'b0, 1'b0, '0);
    add_row(scfr_pkg::CMD_GET_ID, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h7c, 1'b0, 1'b0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    burst_left = $urandom_range(1, 12);
    foreach (frame_table[i])
      transfer_byte(frame_table[i].rx, frame_table[i].typed, frame_table[i].has_res,
                    frame_table[i].res);
    wait_drained();

    phase_ids = '{8'h00, 8'hff, 8'($urandom_range(0, 255)), scfr_pkg::RESET_ID,
                  8'($urandom_range(0, 255))};
    for (int p = 0; p < 5; p++) begin
      write_default_id(phase_ids[p]);
      steady_sender = (p == 3);
      // The receiver holds off while frames keep coming, so the block fills.
      if (p == 0) hold_request = LONG_HOLD;
      frame_items = 0;
      while (frame_items < PHASE_ITEMS) begin
        send_random_frame();
        if (p == 4 && frame_items >= PHASE_ITEMS / 2 && frame_items < PHASE_ITEMS / 2 + 6)
          wait_drained();
      end
      wait_drained();
    end

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/scfr_pkg.sv
hw/rtl/scfr_front.sv
hw/rtl/scfr_job_fifo.sv
hw/rtl/scfr_back.sv
hw/rtl/serial_command_frame_responder.sv
tb/tb_top.sv
